>>> rtl/core/hes_pkg.sv
`timescale 1ns / 1ps
package hes_pkg;

   // Field widths
   localparam int unsigned HEIGHT_BITS    = 16;
   localparam int unsigned SIDE_BITS      = 9;
   localparam int unsigned THR_BITS       = 15;
   localparam int unsigned CSR_DATA_BITS  = THR_BITS;
   localparam int unsigned CSR_INDEX_BITS = 2;

   // Default frame limit
   localparam int unsigned MAX_SIDE_DEFAULT = 256;

   // Register reset values
   localparam logic [SIDE_BITS-1:0] SIDE_RESET = SIDE_BITS'(256);
   localparam logic [THR_BITS-1:0]  THR_RESET  = THR_BITS'(256);

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIDE_X   = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIDE_Y   = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DROP_THR = CSR_INDEX_BITS'(2);

   // Item opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_DRAIN  = 1'b1;

   typedef struct packed {
      logic                          opcode;
      logic signed [HEIGHT_BITS-1:0] height_in;
   } hes_req_type;

   typedef struct packed {
      logic signed [HEIGHT_BITS-1:0] height_out;
      logic                          frame_last;
   } hes_rsp_type;

   // Decoded item handed from the frame control to the erode stage
   typedef struct packed {
      logic                          go;        // item enters the erode stage
      logic                          drain;     // drain of a last-row cell
      logic                          has_out;   // item produces a result
      logic                          erodable;  // cell lies in the eroded interior
      logic                          last;      // final cell of the frame
      logic signed [HEIGHT_BITS-1:0] sample;    // raw sample (lower neighbor)
   } hes_stage_type;

endpackage

>>> rtl/core/hes_ram.sv
`timescale 1ns / 1ps
module hes_ram #(
   parameter int unsigned WIDTH = hes_pkg::HEIGHT_BITS,
   parameter int unsigned DEPTH = hes_pkg::MAX_SIDE_DEFAULT + 2,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port; read returns old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/hes_frame_ctrl.sv
`timescale 1ns / 1ps
module hes_frame_ctrl #(
   parameter int unsigned MAX_SIDE = hes_pkg::MAX_SIDE_DEFAULT,
   localparam int unsigned CNT_W  = $clog2(MAX_SIDE + 3),
   localparam int unsigned ADDR_W = $clog2(MAX_SIDE + 2)
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_wr_en,
   input  logic [hes_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [hes_pkg::CSR_DATA_BITS-1:0]       csr_wdata,
   input  logic                                    req_fire,
   input  hes_pkg::hes_req_type                    req_data,
   output hes_pkg::hes_stage_type                  entry,
   output logic [ADDR_W-1:0]                       entry_col,
   output logic [hes_pkg::THR_BITS-1:0]            drop_thr,
   output logic                                    raw_wr_en,
   output logic [ADDR_W-1:0]                       raw_wr_addr,
   output logic signed [hes_pkg::HEIGHT_BITS-1:0]  raw_wr_data,
   output logic                                    raw_rd_en,
   output logic [ADDR_W-1:0]                       raw_rd_addr,
   output logic                                    up_rd_en,
   output logic [ADDR_W-1:0]                       up_rd_addr
);
   import hes_pkg::*;

   // Clamp a written size to 3..MAX_SIDE
   function automatic logic [CNT_W-1:0] clamp_side(input logic [SIDE_BITS-1:0] v);
      logic [31:0] v_x;
      v_x = 32'(v);
      if (v_x < 32'd3) begin
         return CNT_W'(3);
      end else if (v_x > 32'(MAX_SIDE)) begin
         return CNT_W'(MAX_SIDE);
      end else begin
         return CNT_W'(v_x);
      end
   endfunction

   logic [CNT_W-1:0]    sx_ff, sx_in;
   logic [CNT_W-1:0]    sy_ff, sy_in;
   logic [THR_BITS-1:0] thr_ff, thr_in;
   logic [CNT_W-1:0]    col_ff, col_in;
   logic [CNT_W-1:0]    row_ff, row_in;
   logic [CNT_W-1:0]    drain_ff, drain_in;

   logic [CNT_W-1:0] w_size;
   logic [CNT_W-1:0] h_size;
   logic             is_drain;
   logic             sample_ok;
   logic             drain_ok;
   logic             col_wrap;
   logic             drain_last;
   logic [CNT_W-1:0] col_next;

   // Item decode against the frame position
   always_comb begin
      w_size     = sx_ff + CNT_W'(2);
      h_size     = sy_ff + CNT_W'(2);
      is_drain   = (req_data.opcode == OP_DRAIN);
      sample_ok  = !is_drain && (row_ff < h_size);
      drain_ok   = is_drain && (row_ff == h_size) && (drain_ff < w_size);
      col_wrap   = (col_ff == w_size - CNT_W'(1));
      drain_last = (drain_ff == w_size - CNT_W'(1));
      col_next   = col_wrap ? '0 : col_ff + CNT_W'(1);
   end

   // Stage entry: the cell one row up is finished by this sample
   always_comb begin
      entry.go       = sample_ok || drain_ok;
      entry.drain    = is_drain;
      entry.has_out  = drain_ok || (sample_ok && (row_ff != '0));
      entry.erodable = !is_drain && (row_ff >= CNT_W'(3)) && (row_ff <= sy_ff) &&
                       (col_ff >= CNT_W'(2)) && (col_ff < sx_ff);
      entry.last     = is_drain && drain_last;
      entry.sample   = req_data.height_in;
   end

   assign entry_col = col_ff[ADDR_W-1:0];
   assign drop_thr  = thr_ff;

   // Raw line: write this column, read the next (wraps to 0) or drain column
   assign raw_wr_en   = req_fire && sample_ok;
   assign raw_wr_addr = col_ff[ADDR_W-1:0];
   assign raw_wr_data = req_data.height_in;
   assign raw_rd_en   = req_fire && (sample_ok || drain_ok);
   assign raw_rd_addr = is_drain ? drain_ff[ADDR_W-1:0] : col_next[ADDR_W-1:0];

   // Eroded line: cell two rows up at this column
   assign up_rd_en   = req_fire && sample_ok;
   assign up_rd_addr = col_ff[ADDR_W-1:0];

   // Registers and position counters
   always_comb begin
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      thr_in   = thr_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      drain_in = drain_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SIDE_X: begin
               sx_in    = clamp_side(csr_wdata[SIDE_BITS-1:0]);
               col_in   = '0;
               row_in   = '0;
               drain_in = '0;
            end
            CSR_SIDE_Y: begin
               sy_in    = clamp_side(csr_wdata[SIDE_BITS-1:0]);
               col_in   = '0;
               row_in   = '0;
               drain_in = '0;
            end
            CSR_DROP_THR: begin
               thr_in = csr_wdata[THR_BITS-1:0];
            end
            default: begin
            end
         endcase
      end else if (req_fire) begin
         if (drain_ok) begin
            if (drain_last) begin
               col_in   = '0;
               row_in   = '0;
               drain_in = '0;
            end else begin
               drain_in = drain_ff + CNT_W'(1);
            end
         end else if (sample_ok) begin
            col_in = col_next;
            if (col_wrap) begin
               row_in = row_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff    <= clamp_side(SIDE_RESET);
         sy_ff    <= clamp_side(SIDE_RESET);
         thr_ff   <= THR_RESET;
         col_ff   <= '0;
         row_ff   <= '0;
         drain_ff <= '0;
      end else begin
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         thr_ff   <= thr_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         drain_ff <= drain_in;
      end
   end

   // Raw line read-ahead never collides with the write of the same transfer
   assert property (@(posedge clock) disable iff (reset)
      raw_rd_en && raw_wr_en |-> raw_rd_addr != raw_wr_addr)
      else $error("raw line read and write hit the same entry");

   // Draining only happens once the whole frame is in
   assert property (@(posedge clock) disable iff (reset)
      drain_ff != '0 |-> row_ff == h_size)
      else $error("drain count set before the frame is complete");

   // Column position stays inside the row
   assert property (@(posedge clock) disable iff (reset)
      col_ff < w_size)
      else $error("column counter past the row stride");

endmodule

>>> rtl/core/hes_erode_stage.sv
`timescale 1ns / 1ps
module hes_erode_stage #(
   parameter int unsigned MAX_SIDE = hes_pkg::MAX_SIDE_DEFAULT,
   localparam int unsigned ADDR_W = $clog2(MAX_SIDE + 2)
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_fire,
   input  hes_pkg::hes_stage_type                  entry,
   input  logic [ADDR_W-1:0]                       entry_col,
   input  logic [hes_pkg::THR_BITS-1:0]            drop_thr,
   input  logic signed [hes_pkg::HEIGHT_BITS-1:0]  raw_rd_data,
   input  logic signed [hes_pkg::HEIGHT_BITS-1:0]  up_rd_data,
   output logic                                    take_ok,
   output logic                                    up_wr_en,
   output logic [ADDR_W-1:0]                       up_wr_addr,
   output logic signed [hes_pkg::HEIGHT_BITS-1:0]  up_wr_data,
   input  logic                                    rsp_ready,
   output logic                                    rsp_valid,
   output hes_pkg::hes_rsp_type                    rsp_data
);
   import hes_pkg::*;

   localparam int unsigned DROP_W =
      ((HEIGHT_BITS > THR_BITS) ? HEIGHT_BITS : THR_BITS + 1) + 1;

   typedef logic signed [DROP_W-1:0] drop_type;

   function automatic drop_type widen(input logic signed [HEIGHT_BITS-1:0] v);
      return drop_type'({{(DROP_W-HEIGHT_BITS){v[HEIGHT_BITS-1]}}, v});
   endfunction

   logic                          s1_valid_ff, s1_valid_in;
   hes_stage_type                 s1_ff, s1_in;
   logic [ADDR_W-1:0]             s1_col_ff, s1_col_in;
   logic signed [HEIGHT_BITS-1:0] cur_ff, cur_in;
   logic signed [HEIGHT_BITS-1:0] left_ff, left_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   hes_rsp_type                   rsp_data_ff, rsp_data_in;

   drop_type                      cur_x;
   drop_type                      thr_x;
   drop_type                      drop_l, drop_r, drop_d, drop_u;
   drop_type                      max_lr, max_du, best;
   drop_type                      lowered;
   logic                          hit;
   logic signed [HEIGHT_BITS-1:0] cell_value;
   logic signed [HEIGHT_BITS-1:0] out_value;
   logic                          out_free;
   logic                          s1_adv;
   logic                          emit;

   // Four drops against left/upper eroded and right/lower raw neighbors
   always_comb begin
      cur_x   = widen(cur_ff);
      thr_x   = drop_type'({{(DROP_W-THR_BITS){1'b0}}, drop_thr});
      drop_l  = cur_x - widen(left_ff);
      drop_r  = cur_x - widen(raw_rd_data);
      drop_d  = cur_x - widen(s1_ff.sample);
      drop_u  = cur_x - widen(up_rd_data);
      max_lr  = (drop_l > drop_r) ? drop_l : drop_r;
      max_du  = (drop_d > drop_u) ? drop_d : drop_u;
      best    = (max_lr > max_du) ? max_lr : max_du;
      hit     = s1_ff.erodable && (best > thr_x);
      lowered = cur_x - (best >>> 1);
      cell_value = hit ? lowered[HEIGHT_BITS-1:0] : cur_ff;
      out_value  = s1_ff.drain ? raw_rd_data : cell_value;
   end

   // Flow control: output register parts the two sides
   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      s1_adv   = s1_valid_ff && (!s1_ff.has_out || out_free);
      take_ok  = !s1_valid_ff || s1_adv;
      emit     = s1_adv && s1_ff.has_out;
   end

   // Eroded cell goes back into the eroded line
   assign up_wr_en   = emit && !s1_ff.drain;
   assign up_wr_addr = s1_col_ff;
   assign up_wr_data = cell_value;

   // Next state
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      s1_col_in   = s1_col_ff;
      if (req_fire && entry.go) begin
         s1_valid_in = 1'b1;
         s1_in       = entry;
         s1_col_in   = entry_col;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      // Read-ahead value becomes the next cell; this result the next left
      cur_in  = cur_ff;
      left_in = left_ff;
      if (s1_adv && !s1_ff.drain) begin
         cur_in  = raw_rd_data;
         left_in = cell_value;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.height_out = out_value;
         rsp_data_in.frame_last = s1_ff.last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff       <= s1_in;
      s1_col_ff   <= s1_col_in;
      cur_ff      <= cur_in;
      left_ff     <= left_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Erosion only ever lowers a cell
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ff.erodable |-> cell_value <= cur_ff)
      else $error("eroded cell above its original height");

endmodule

>>> rtl/core/heightmap_erosion_stencil_unit.sv
`timescale 1ns / 1ps
// One in-place thermal erosion pass over a heightmap streamed in raster order:
// rows of side_x+2 signed Q8.8 heights, side_y+2 rows per frame. Interior cells
// lose half of their largest neighbor drop above drop_threshold. Results lag
// their samples by one row; after the last sample, side_x+2 drain items
// flush the final row, the last one flagged with frame_last. The block takes
// one item per clock sustained while the result side is not stalling. The
// result an item releases passes the erode stage register and is then loaded
// into the output register, which holds it until the result transfer. The rate
// is set by the loop in the erode stage, where each cell's compare-and-subtract
// consumes the eroded left neighbor registered from the previous cell. Two line
// memories of MAX_SIDE+2 entries hold the previous raw row and the previous
// eroded row; they need no clearing after reset. Writing side_x or side_y
// restarts the frame; configuration is to be written only while the block is
// idle; the block itself does not enforce this.
module heightmap_erosion_stencil_unit #(
   parameter int unsigned MAX_SIDE = hes_pkg::MAX_SIDE_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  hes_pkg::hes_req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output hes_pkg::hes_rsp_type                rsp_data,
   input  logic                                csr_wr_en,
   input  logic [hes_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [hes_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import hes_pkg::*;

   localparam int unsigned LINE_DEPTH = MAX_SIDE + 2;
   localparam int unsigned ADDR_W     = $clog2(LINE_DEPTH);

   logic                          req_fire;
   logic                          take_ok;
   hes_stage_type                 entry;
   logic [ADDR_W-1:0]             entry_col;
   logic [THR_BITS-1:0]           drop_thr;

   logic                          raw_wr_en;
   logic [ADDR_W-1:0]             raw_wr_addr;
   logic signed [HEIGHT_BITS-1:0] raw_wr_data;
   logic                          raw_rd_en;
   logic [ADDR_W-1:0]             raw_rd_addr;
   logic signed [HEIGHT_BITS-1:0] raw_rd_data;

   logic                          up_wr_en;
   logic [ADDR_W-1:0]             up_wr_addr;
   logic signed [HEIGHT_BITS-1:0] up_wr_data;
   logic                          up_rd_en;
   logic [ADDR_W-1:0]             up_rd_addr;
   logic signed [HEIGHT_BITS-1:0] up_rd_data;

   // Input transfer
   assign req_ready = take_ok;
   assign req_fire  = req_valid && take_ok;

   // Frame position, registers and line addressing
   hes_frame_ctrl #(
      .MAX_SIDE (MAX_SIDE)
   ) u_frame_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_fire    (req_fire),
      .req_data    (req_data),
      .entry       (entry),
      .entry_col   (entry_col),
      .drop_thr    (drop_thr),
      .raw_wr_en   (raw_wr_en),
      .raw_wr_addr (raw_wr_addr),
      .raw_wr_data (raw_wr_data),
      .raw_rd_en   (raw_rd_en),
      .raw_rd_addr (raw_rd_addr),
      .up_rd_en    (up_rd_en),
      .up_rd_addr  (up_rd_addr)
   );

   // Previous raw row
   hes_ram #(
      .WIDTH (HEIGHT_BITS),
      .DEPTH (LINE_DEPTH)
   ) u_raw_line (
      .clock   (clock),
      .wr_en   (raw_wr_en),
      .wr_addr (raw_wr_addr),
      .wr_data (raw_wr_data),
      .rd_en   (raw_rd_en),
      .rd_addr (raw_rd_addr),
      .rd_data (raw_rd_data)
   );

   // Previous eroded row
   hes_ram #(
      .WIDTH (HEIGHT_BITS),
      .DEPTH (LINE_DEPTH)
   ) u_up_line (
      .clock   (clock),
      .wr_en   (up_wr_en),
      .wr_addr (up_wr_addr),
      .wr_data (up_wr_data),
      .rd_en   (up_rd_en),
      .rd_addr (up_rd_addr),
      .rd_data (up_rd_data)
   );

   // Stencil compute and output register
   hes_erode_stage #(
      .MAX_SIDE (MAX_SIDE)
   ) u_erode_stage (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .entry       (entry),
      .entry_col   (entry_col),
      .drop_thr    (drop_thr),
      .raw_rd_data (raw_rd_data),
      .up_rd_data  (up_rd_data),
      .take_ok     (take_ok),
      .up_wr_en    (up_wr_en),
      .up_wr_addr  (up_wr_addr),
      .up_wr_data  (up_wr_data),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   // Eroded line read of the new column never meets the write-back
   assert property (@(posedge clock) disable iff (reset)
      up_rd_en && up_wr_en |-> up_rd_addr != up_wr_addr)
      else $error("eroded line read and write hit the same entry");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import hes_pkg::*;

   localparam int unsigned MAX_SIDE      = MAX_SIDE_DEFAULT;
   localparam int unsigned LINE_DEPTH    = 2 * (MAX_SIDE + 2);
   localparam int unsigned MAX_CELLS     = (MAX_SIDE + 2) * (MAX_SIDE + 2);
   localparam int unsigned WIDE_CELLS    = 300;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned RANDOM_ITEMS  = 320;
   localparam int unsigned TIMEOUT_NS    = 8_000_000;

   // Index with no register behind it
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED = CSR_INDEX_BITS'(3);

   typedef enum logic [1:0] {ROW_SAMPLE, ROW_DRAIN, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_TYPED} row_exp_type;

   typedef struct packed {
      row_kind_type              kind;
      row_exp_type               chk;
      logic [CSR_INDEX_BITS-1:0] idx;
      logic [HEIGHT_BITS-1:0]    arg;        // height, or register data
      logic [HEIGHT_BITS-1:0]    exp_height;
      logic                      exp_last;
   } step_row_type;

   // Directed frame: 5x5 after clamping, one interior cell at row 2, column 2.
   // That cell holds the top height and has two bottom-height neighbors (a tie);
   // its upper and lower drops equal the threshold exactly and so do not count.
   localparam int DIRECTED_ROWS = 36;
   localparam step_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{ROW_DRAIN,  EXP_NONE,  CSR_SIDE_X,   16'hABCD, 16'h0000, 1'b0}, // early drain
      '{ROW_CSR,    EXP_NONE,  CSR_SIDE_X,   16'h0000, 16'h0000, 1'b0}, // clamps to 3
      '{ROW_CSR,    EXP_NONE,  CSR_SIDE_Y,   16'h0002, 16'h0000, 1'b0}, // clamps to 3
      '{ROW_CSR,    EXP_NONE,  CSR_DROP_THR, 16'h7FFF, 16'h0000, 1'b0},
      '{ROW_CSR,    EXP_NONE,  CSR_UNMAPPED, 16'h7FFF, 16'h0000, 1'b0}, // no effect
      // row 0: no results yet
      '{ROW_SAMPLE, EXP_NONE,  CSR_SIDE_X,   16'h8000, 16'h0000, 1'b0},
      '{ROW_SAMPLE, EXP_NONE,  CSR_SIDE_X,   16'h7FFF, 16'h0000, 1'b0},
      '{ROW_SAMPLE, EXP_NONE,  CSR_SIDE_X,   16'h0000, 16'h0000, 1'b0},
      '{ROW_SAMPLE, EXP_NONE,  CSR_SIDE_X,   16'h0001, 16'h0000, 1'b0},
      '{ROW_SAMPLE, EXP_NONE,  CSR_SIDE_X,   16'hFFFF, 16'h0000, 1'b0},
      // row 1: row 0 passes through
      '{ROW_SAMPLE, EXP_TYPED, CSR_SIDE_X,   16'h0040, 16'h8000, 1'b0},
      '{ROW_SAMPLE, EXP_TYPED, CSR_SIDE_X,   16'h1234, 16'h7FFF, 1'b0},
      '{ROW_SAMPLE, EXP_MODEL, CSR_SIDE_X,   16'h0000, 16'h0000, 1'b0},
      '{ROW_SAMPLE, EXP_MODEL, CSR_SIDE_X,   16'h00FF, 16'h0000, 1'b0},
      '{ROW_SAMPLE, EXP_TYPED, CSR_SIDE_X,   16'hFF00, 16'hFFFF, 1'b0},
      // row 2
      '{ROW_SAMPLE, EXP_MODEL, CSR_SIDE_X,   16'h0064, 16'h0000, 1'b0},
      '{ROW_SAMPLE, EXP_MODEL, CSR_SIDE_X,   16'h8000, 16'h0000, 1'b0},
      '{ROW_SAMPLE, EXP_MODEL, CSR_SIDE_X,   16'h7FFF, 16'h0000, 1'b0},
      '{ROW_SAMPLE, EXP_MODEL, CSR_SIDE_X,   16'h8000, 16'h0000, 1'b0},
      '{ROW_SAMPLE, EXP_MODEL, CSR_SIDE_X,   16'h0007, 16'h0000, 1'b0},
      // row 3: the interior cell erodes from top height down to zero
      '{ROW_SAMPLE, EXP_MODEL, CSR_SIDE_X,   16'h0100, 16'h0000, 1'b0},
      '{ROW_SAMPLE, EXP_MODEL, CSR_SIDE_X,   16'h0200, 16'h0000, 1'b0},
      '{ROW_SAMPLE, EXP_TYPED, CSR_SIDE_X,   16'h0000, 16'h0000, 1'b0},
      '{ROW_SAMPLE, EXP_MODEL, CSR_SIDE_X,   16'h0300, 16'h0000, 1'b0},
      '{ROW_SAMPLE, EXP_MODEL, CSR_SIDE_X,   16'h0400, 16'h0000, 1'b0},
      // row 4
      '{ROW_SAMPLE, EXP_MODEL, CSR_SIDE_X,   16'h0A00, 16'h0000, 1'b0},
      '{ROW_SAMPLE, EXP_MODEL, CSR_SIDE_X,   16'h0B00, 16'h0000, 1'b0},
      '{ROW_SAMPLE, EXP_MODEL, CSR_SIDE_X,   16'h0C00, 16'h0000, 1'b0},
      '{ROW_SAMPLE, EXP_MODEL, CSR_SIDE_X,   16'h0D00, 16'h0000, 1'b0},
      '{ROW_SAMPLE, EXP_MODEL, CSR_SIDE_X,   16'h7FFF, 16'h0000, 1'b0},
      // frame is full: sample dropped
      '{ROW_SAMPLE, EXP_NONE,  CSR_SIDE_X,   16'h5555, 16'h0000, 1'b0},
      // flush the last row
      '{ROW_DRAIN,  EXP_MODEL, CSR_SIDE_X,   16'h0000, 16'h0000, 1'b0},
      '{ROW_DRAIN,  EXP_MODEL, CSR_SIDE_X,   16'hFFFF, 16'h0000, 1'b0},
      '{ROW_DRAIN,  EXP_MODEL, CSR_SIDE_X,   16'h1111, 16'h0000, 1'b0},
      '{ROW_DRAIN,  EXP_MODEL, CSR_SIDE_X,   16'h2222, 16'h0000, 1'b0},
      '{ROW_DRAIN,  EXP_TYPED, CSR_SIDE_X,   16'h3333, 16'h7FFF, 1'b1}
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   hes_req_type               req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   hes_rsp_type               rsp_data;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Mirror of the block: registers, line memory and frame position
   logic [SIDE_BITS-1:0]          cfg_side_x = SIDE_RESET;
   logic [SIDE_BITS-1:0]          cfg_side_y = SIDE_RESET;
   logic [THR_BITS-1:0]           cfg_thr    = THR_RESET;
   logic signed [HEIGHT_BITS-1:0] line_mem [LINE_DEPTH];
   int unsigned                   next_col = 0;
   int unsigned                   next_row = 0;
   int unsigned                   drained  = 0;

   hes_rsp_type eroded_cells [$];
   int          error_count  = 0;
   int unsigned stream_items = 0;
   bit          send_gaps_on = 1'b1;
   bit          recv_gaps_on = 1'b1;
   bit          hold_rsp     = 1'b0;

   heightmap_erosion_stencil_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int unsigned eff_side(logic [SIDE_BITS-1:0] s);
      if (s < 3) return 3;
      if (s > MAX_SIDE) return MAX_SIDE;
      return s;
   endfunction

   function automatic void restart_frame();
      next_col = 0;
      next_row = 0;
      drained  = 0;
   endfunction

   function automatic void set_register(logic [CSR_INDEX_BITS-1:0] idx,
                                        logic [CSR_DATA_BITS-1:0] value);
      case (idx)
         CSR_SIDE_X: begin
            cfg_side_x = value[SIDE_BITS-1:0];
            restart_frame();
         end
         CSR_SIDE_Y: begin
            cfg_side_y = value[SIDE_BITS-1:0];
            restart_frame();
         end
         CSR_DROP_THR: cfg_thr = value[THR_BITS-1:0];
         default: ;
      endcase
   endfunction

   // Erodes the cell one row behind the sample; returns 1 when a result leaves
   function automatic bit erode_cell(input hes_req_type item, output hes_rsp_type res);
      int unsigned sx, sy, w, h, new_slot, cell_slot, cell_row;
      int          cur, best, d;
      int          nbr [4];
      bit          hit;
      bit          produced;
      sx  = eff_side(cfg_side_x);
      sy  = eff_side(cfg_side_y);
      w   = sx + 2;
      h   = sy + 2;
      res = '0;
      produced = 1'b0;

      // drain: only once the whole frame is in
      if (item.opcode == OP_DRAIN) begin
         if (next_row != h || drained >= w) return 1'b0;
         res.height_out = line_mem[((h - 1) % 2) * w + drained];
         res.frame_last = (drained == w - 1);
         if (res.frame_last) restart_frame();
         else drained++;
         return 1'b1;
      end

      if (next_row >= h || next_col >= w) return 1'b0;
      new_slot = (next_row % 2) * w + next_col;
      if (next_row >= 1) begin
         cell_row  = next_row - 1;
         cell_slot = (cell_row % 2) * w + next_col;
         cur       = line_mem[cell_slot];
         if (cell_row >= 2 && cell_row <= sy - 1 && next_col >= 2 && next_col <= sx - 1) begin
            // left eroded, right raw, lower is this sample, upper eroded
            nbr[0] = line_mem[cell_slot - 1];
            nbr[1] = line_mem[cell_slot + 1];
            nbr[2] = item.height_in;
            nbr[3] = line_mem[new_slot];
            best   = 0;
            hit    = 1'b0;
            foreach (nbr[k]) begin
               d = cur - nbr[k];
               if (d > int'(cfg_thr) && d > best) begin
                  best = d;
                  hit  = 1'b1;
               end
            end
            if (hit) begin
               cur = cur - (best >>> 1);
               line_mem[cell_slot] = cur[HEIGHT_BITS-1:0];
            end
         end
         res.height_out = cur[HEIGHT_BITS-1:0];
         produced = 1'b1;
      end
      line_mem[new_slot] = item.height_in;
      next_col++;
      if (next_col >= w) begin
         next_col = 0;
         next_row++;
      end
      return produced;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [HEIGHT_BITS-1:0] terrain_height(logic [HEIGHT_BITS-1:0] base,
                                                            int unsigned spread);
      case ($urandom_range(0, 15))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2, 3: return HEIGHT_BITS'($urandom);
         default: return base + HEIGHT_BITS'($urandom_range(0, spread));
      endcase
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_side();
      int unsigned s;
      case ($urandom_range(0, 9))
         0: s = $urandom_range(0, 2);
         1: s = $urandom_range(9, 16);
         default: s = $urandom_range(3, 8);
      endcase
      // upper data bits are junk for a size register
      return {6'($urandom), 9'(s)};
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_threshold();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 15'h7FFF;
         2, 3: return 15'($urandom_range(0, 1023));
         default: return 15'($urandom);
      endcase
   endfunction

   // One input transfer; the expectation is queued at the accepting edge
   task automatic send_item(input logic op, input logic [HEIGHT_BITS-1:0] height,
                            input row_exp_type chk = EXP_MODEL,
                            input hes_rsp_type typed = '0);
      hes_req_type item;
      hes_rsp_type res;
      bit          produced;
      int          gap;
      item.opcode    = op;
      item.height_in = height;
      gap = send_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      produced = erode_cell(item, res);
      case (chk)
         EXP_MODEL: if (produced) eroded_cells.push_back(res);
         EXP_TYPED: eroded_cells.push_back(typed);
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (eroded_cells.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      set_register(idx, value);
   endtask

   // One frame of terrain around a random base level, drains included;
   // a frame cut short at max_cells samples, or at random when may_abort is set, sends no drains
   task automatic stream_frame(input bit may_abort, input int unsigned max_cells,
                               output bit aborted);
      int unsigned            w, h, cells, cut, spread;
      logic [HEIGHT_BITS-1:0] base;
      w      = eff_side(cfg_side_x) + 2;
      h      = eff_side(cfg_side_y) + 2;
      cells  = w * h;
      base   = HEIGHT_BITS'($urandom);
      spread = $urandom_range(0, 2 * cfg_thr + 600);
      cut    = (may_abort && $urandom_range(0, 9) == 0) ? $urandom_range(1, cells - 1) : cells;
      if (cut > max_cells) cut = max_cells;
      aborted = (cut < cells);
      for (int unsigned n = 0; n < cut; n++) begin
         // drain before the frame is complete is dropped
         if ($urandom_range(0, 39) == 0) send_item(OP_DRAIN, HEIGHT_BITS'($urandom));
         send_item(OP_SAMPLE, terrain_height(base, spread));
      end
      stream_items += cut;
      if (aborted) return;
      // sample into a full frame is dropped
      if ($urandom_range(0, 4) == 0) send_item(OP_SAMPLE, HEIGHT_BITS'($urandom));
      for (int unsigned n = 0; n < w; n++) send_item(OP_DRAIN, HEIGHT_BITS'($urandom));
      stream_items += w;
      if ($urandom_range(0, 9) == 0) send_item(OP_DRAIN, HEIGHT_BITS'($urandom));
   endtask

   // Result side: random stalls, plus one long hold on request
   initial begin
      int gap;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         gap = recv_gaps_on ? pick_gap() : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      hes_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (eroded_cells.size() == 0) begin
            $display("%0t: unexpected result, actual height %h last %b",
                     $time, rsp_data.height_out, rsp_data.frame_last);
            error_count++;
         end else begin
            want = eroded_cells.pop_front();
            if (rsp_data.height_out !== want.height_out) begin
               $display("%0t: height_out mismatch, expected %h, actual %h",
                        $time, want.height_out, rsp_data.height_out);
               error_count++;
            end
            if (rsp_data.frame_last !== want.frame_last) begin
               $display("%0t: frame_last mismatch, expected %b, actual %b",
                        $time, want.frame_last, rsp_data.frame_last);
               error_count++;
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      step_row_type row;
      bit           aborted;
      int           frame_no;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = DIRECTED[i];
         if (row.kind == ROW_CSR) begin
            write_reg(row.idx, row.arg[CSR_DATA_BITS-1:0]);
         end else begin
            send_item((row.kind == ROW_DRAIN) ? OP_DRAIN : OP_SAMPLE, row.arg, row.chk,
                      {row.exp_height, row.exp_last});
         end
      end

      // widest rows (size above range) with zero threshold, back to back;
      // the frame stops once the column count has wrapped into the second row
      send_gaps_on = 1'b0;
      write_reg(CSR_SIDE_X, 15'd511);
      write_reg(CSR_SIDE_Y, 15'd3);
      write_reg(CSR_DROP_THR, '0);
      stream_frame(1'b0, WIDE_CELLS, aborted);

      // random frames, small sizes
      stream_items = 0;
      frame_no     = 0;
      aborted      = 1'b0;
      while (stream_items < RANDOM_ITEMS || frame_no < 3) begin
         send_gaps_on = ($urandom_range(0, 3) != 0);
         recv_gaps_on = ($urandom_range(0, 3) != 0);
         if (aborted || frame_no == 0 || $urandom_range(0, 2) == 0) begin
            write_reg(CSR_SIDE_X, pick_side());
            write_reg(CSR_SIDE_Y, pick_side());
         end
         if ($urandom_range(0, 2) == 0) write_reg(CSR_DROP_THR, pick_threshold());
         else if ($urandom_range(0, 4) == 0) wait_idle();
         // result side holds off while this frame keeps coming
         if (frame_no == 2) hold_rsp = 1'b1;
         stream_frame(1'b1, MAX_CELLS, aborted);
         frame_no++;
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
